[rtl/hntc_pkg.sv]
// Package: types, constants and hash tables for the name counter hash table.
`default_nettype none
package hntc_pkg;

  localparam int TableSize    = 103;
  localparam int NameBytes    = 30;
  localparam int SlotW        = $clog2(TableSize);
  localparam int ByteW        = $clog2(NameBytes);
  localparam int KeyDepth     = 1 << ByteW;
  localparam int KeyLenW      = $clog2(NameBytes + 1);
  localparam int NameMemDepth = TableSize * KeyDepth;
  localparam int NameAddrW    = $clog2(NameMemDepth);
  localparam int CharW        = 7;
  localparam int CountW       = 16;

  localparam logic [CountW-1:0] CountMax = '1;

  typedef enum logic {
    ACT_INSERT = 1'b0,
    ACT_LOOKUP = 1'b1
  } action_e;

  typedef struct packed {
    logic             action;
    logic [CharW-1:0] char_code;
    logic             last;
  } item_t;

  typedef struct packed {
    logic              found;
    logic [CountW-1:0] occurrences;
    logic [6:0]        slot;
    logic              table_full;
    logic [6:0]        distinct_names;
    logic [CountW-1:0] collisions;
  } result_t;

  // controller -> datapath
  typedef struct packed {
    logic accept;
    logic slot_rd;
    logic byte_rd;
    logic next_byte;
    logic remap;
    logic set_found;
    logic set_full;
    logic commit;
    logic copy_wr;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic last_in;
    logic slot_empty;
    logic len_eq;
    logic key_empty;
    logic byte_eq;
    logic byte_last;
    logic probe_end;
    logic insert;
    logic found;
  } stat_t;

  typedef logic [SlotW-1:0] weight_tbl_t [2*(1<<CharW)];
  typedef logic [SlotW-1:0] remap_tbl_t  [TableSize];

  // character weight, already reduced modulo the table size; index {select, char}
  function automatic weight_tbl_t build_weight();
    weight_tbl_t t;
    int          c;
    int          w;
    for (int i = 0; i < 2*(1<<CharW); i++) begin
      c = i & ((1 << CharW) - 1);
      w = c;
      if (i >= (1 << CharW)) begin
        if (c == 111 || c == 79) w = c * 31;
        else if (c == 110 || c == 78) w = c * 51;
        else if (c == 118 || c == 86) w = (c * 147) >> 10;  // c/7, exact for 7-bit codes
        else if (c == 101 || c == 69) w = c * 71;
      end
      while (w >= TableSize) w = w - TableSize;
      t[i] = SlotW'(w);
    end
    return t;
  endfunction

  function automatic remap_tbl_t build_remap();
    remap_tbl_t t;
    longint     v;
    for (int i = 0; i < TableSize; i++) begin
      v = longint'(i) * 8241;
      if (v < 20000) v = (v >= 279) ? (v - 279) : (279 - v);
      else v = v + 371;
      // restoring reduction modulo the table size
      for (int m = 1 << 13; m >= 1; m = m >> 1)
        if (v >= longint'(TableSize) * m) v = v - longint'(TableSize) * m;
      t[i] = SlotW'(v);
    end
    return t;
  endfunction

  localparam weight_tbl_t WeightTbl = build_weight();
  localparam remap_tbl_t  RemapTbl  = build_remap();

endpackage
`default_nettype wire

[rtl/hntc_ctrl.sv]
// Controller: sequences key intake, probing, byte compare, commit, copy and emit.
`default_nettype none
module hntc_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  input  hntc_pkg::stat_t    stat_i,
  output hntc_pkg::cmd_t     cmd_o
);

  typedef enum logic [7:0] {
    ST_IDLE     = 8'b0000_0001,
    ST_SLOT_RD  = 8'b0000_0010,
    ST_SLOT_CHK = 8'b0000_0100,
    ST_BYTE_RD  = 8'b0000_1000,
    ST_BYTE_CHK = 8'b0001_0000,
    ST_COMMIT   = 8'b0010_0000,
    ST_COPY     = 8'b0100_0000,
    ST_EMIT     = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;

  assign busy_o = (state_q != ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          cmd_o.accept = 1'b1;
          if (stat_i.last_in) state_d = ST_SLOT_RD;
        end
      end
      ST_SLOT_RD: begin
        cmd_o.slot_rd = 1'b1;
        state_d = ST_SLOT_CHK;
      end
      ST_SLOT_CHK: begin
        if (stat_i.slot_empty) begin
          state_d = ST_COMMIT;
        end else if (stat_i.len_eq && stat_i.key_empty) begin
          cmd_o.set_found = 1'b1;
          state_d = ST_COMMIT;
        end else if (stat_i.len_eq) begin
          state_d = ST_BYTE_RD;
        end else if (stat_i.probe_end) begin
          cmd_o.set_full = 1'b1;
          state_d = ST_EMIT;
        end else begin
          cmd_o.remap = 1'b1;
          state_d = ST_SLOT_RD;
        end
      end
      ST_BYTE_RD: begin
        cmd_o.byte_rd = 1'b1;
        state_d = ST_BYTE_CHK;
      end
      ST_BYTE_CHK: begin
        if (!stat_i.byte_eq) begin
          if (stat_i.probe_end) begin
            cmd_o.set_full = 1'b1;
            state_d = ST_EMIT;
          end else begin
            cmd_o.remap = 1'b1;
            state_d = ST_SLOT_RD;
          end
        end else if (stat_i.byte_last) begin
          cmd_o.set_found = 1'b1;
          state_d = ST_COMMIT;
        end else begin
          cmd_o.next_byte = 1'b1;
          state_d = ST_BYTE_RD;
        end
      end
      ST_COMMIT: begin
        cmd_o.commit = 1'b1;
        if (stat_i.insert && !stat_i.found && !stat_i.key_empty) state_d = ST_COPY;
        else state_d = ST_EMIT;
      end
      ST_COPY: begin
        cmd_o.copy_wr = 1'b1;
        if (stat_i.byte_last) state_d = ST_EMIT;
      end
      ST_EMIT: begin
        cmd_o.emit = 1'b1;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) state_q <= ST_IDLE;
    else state_q <= state_d;
  end

endmodule
`default_nettype wire

[rtl/hntc_dp.sv]
// Datapath: key buffer, running hash, slot memories, probe registers, result register.
`default_nettype none
module hntc_dp (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  hntc_pkg::item_t    item_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  input  hntc_pkg::cmd_t     cmd_i,
  output hntc_pkg::stat_t    stat_o,
  output hntc_pkg::result_t  res_o,
  output logic               done_o
);

  localparam int SlotW   = hntc_pkg::SlotW;
  localparam int ByteW   = hntc_pkg::ByteW;
  localparam int KeyLenW = hntc_pkg::KeyLenW;
  localparam int CharW   = hntc_pkg::CharW;
  localparam int CountW  = hntc_pkg::CountW;

  // slot storage
  logic [CharW-1:0]   name_mem [hntc_pkg::NameMemDepth];
  logic [KeyLenW-1:0] len_mem  [hntc_pkg::TableSize];
  logic [CountW-1:0]  cnt_mem  [hntc_pkg::TableSize];
  logic               vld_q    [hntc_pkg::TableSize];

  logic [CharW-1:0]   key_q [hntc_pkg::KeyDepth];
  logic [KeyLenW-1:0] klen_q;
  logic [SlotW-1:0]   hash_q, hash_d;
  logic               hash_sel_q;
  logic [6:0]         distinct_q;
  logic [CountW-1:0]  coll_q;
  logic               done_q;

  logic [SlotW-1:0]   s_q;
  logic [SlotW-1:0]   k_q;
  logic [ByteW-1:0]   idx_q;
  logic               act_q, found_q, full_q;
  logic [CountW-1:0]  occ_q;
  logic [CountW-1:0]  cnt_rd_q;
  logic               vld_rd_q;
  logic [KeyLenW-1:0] len_rd_q;
  logic [CharW-1:0]   chr_rd_q;
  hntc_pkg::result_t  res_q;

  logic               take;
  logic [SlotW:0]     hash_sum;
  logic [SlotW-1:0]   weight;
  logic [CountW-1:0]  cnt_cur, cnt_new;
  logic [hntc_pkg::NameAddrW-1:0] name_addr;

  assign take     = (item_i.char_code != '0) && (klen_q < KeyLenW'(hntc_pkg::NameBytes));
  assign weight   = hntc_pkg::WeightTbl[{hash_sel_q, item_i.char_code}];
  assign hash_sum = {1'b0, hash_q} + {1'b0, weight};

  always_comb begin
    hash_d = hash_q;
    if (take) begin
      if (hash_sum >= (SlotW+1)'(hntc_pkg::TableSize))
        hash_d = SlotW'(hash_sum - (SlotW+1)'(hntc_pkg::TableSize));
      else
        hash_d = SlotW'(hash_sum);
    end
  end

  assign cnt_cur   = vld_rd_q ? cnt_rd_q : '0;
  assign cnt_new   = (cnt_cur == hntc_pkg::CountMax) ? cnt_cur : cnt_cur + 1'b1;
  assign name_addr = {s_q, idx_q};

  assign stat_o.last_in    = item_i.last;
  assign stat_o.slot_empty = !vld_rd_q;
  assign stat_o.len_eq     = (len_rd_q == klen_q);
  assign stat_o.key_empty  = (klen_q == '0);
  assign stat_o.byte_eq    = (chr_rd_q == key_q[idx_q]);
  assign stat_o.byte_last  = ({1'b0, idx_q} == KeyLenW'(klen_q - 1'b1));
  assign stat_o.probe_end  = (k_q == SlotW'(hntc_pkg::TableSize - 1));
  assign stat_o.insert     = (act_q == hntc_pkg::ACT_INSERT);
  assign stat_o.found      = found_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      klen_q     <= '0;
      hash_q     <= '0;
      hash_sel_q <= 1'b1;
      distinct_q <= '0;
      coll_q     <= '0;
      done_q     <= 1'b0;
      for (int i = 0; i < hntc_pkg::TableSize; i++) vld_q[i] <= 1'b0;
    end else begin
      done_q <= cmd_i.emit;
      if (cfg_we_i) hash_sel_q <= cfg_wdata_i;
      if (cmd_i.accept) begin
        hash_q <= hash_d;
        if (take) klen_q <= klen_q + 1'b1;
      end
      if (cmd_i.remap && act_q == hntc_pkg::ACT_INSERT && coll_q != hntc_pkg::CountMax)
        coll_q <= coll_q + 1'b1;
      if (cmd_i.commit && act_q == hntc_pkg::ACT_INSERT) begin
        vld_q[s_q] <= 1'b1;
        if (!found_q) distinct_q <= distinct_q + 1'b1;
      end
      if (cmd_i.emit) begin
        klen_q <= '0;
        hash_q <= '0;
      end
    end
  end

  // probe and payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      if (take) key_q[klen_q[ByteW-1:0]] <= item_i.char_code;
      s_q     <= hash_d;
      k_q     <= '0;
      act_q   <= item_i.action;
      found_q <= 1'b0;
      full_q  <= 1'b0;
    end
    if (cmd_i.slot_rd) begin
      vld_rd_q <= vld_q[s_q];
      idx_q    <= '0;
    end
    if (cmd_i.next_byte) idx_q <= idx_q + 1'b1;
    if (cmd_i.remap) begin
      s_q <= hntc_pkg::RemapTbl[s_q];
      k_q <= k_q + 1'b1;
    end
    if (cmd_i.set_found) found_q <= 1'b1;
    if (cmd_i.set_full) begin
      full_q <= 1'b1;
      occ_q  <= '0;
    end
    if (cmd_i.commit) begin
      occ_q <= (act_q == hntc_pkg::ACT_INSERT) ? cnt_new : cnt_cur;
      idx_q <= '0;
    end
    if (cmd_i.copy_wr) idx_q <= idx_q + 1'b1;
    if (cmd_i.emit) begin
      res_q.found          <= found_q;
      res_q.occurrences    <= occ_q;
      res_q.slot           <= 7'(s_q);
      res_q.table_full     <= full_q;
      res_q.distinct_names <= distinct_q;
      res_q.collisions     <= coll_q;
    end
  end

  // slot count memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && act_q == hntc_pkg::ACT_INSERT) cnt_mem[s_q] <= cnt_new;
    if (cmd_i.slot_rd) cnt_rd_q <= cnt_mem[s_q];
  end

  // name length memory
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit && act_q == hntc_pkg::ACT_INSERT && !found_q) len_mem[s_q] <= klen_q;
    if (cmd_i.slot_rd) len_rd_q <= len_mem[s_q];
  end

  // name character memory, one row of KeyDepth bytes per slot
  always_ff @(posedge clk_i) begin
    if (cmd_i.copy_wr) name_mem[name_addr] <= key_q[idx_q];
    if (cmd_i.byte_rd) chr_rd_q <= name_mem[name_addr];
  end

  assign res_o  = res_q;
  assign done_o = done_q;

endmodule
`default_nettype wire

[rtl/hash_table_name_counter.sv]
// Top level: open-addressing name counter, controller plus datapath.
//
//  channel | signals                   | beat
//  --------+---------------------------+----------------------------------
//  item    | start, busy, item_i       | start high while busy low
//  result  | done_o, res_o             | done_o high for one cycle
//  config  | cfg_we_i, cfg_wdata_i     | cfg_we_i high (hash_select)
//
// A character without last is accepted while busy stays low.
// A last character: accept, a slot read and check per probed slot, a byte read and
// check per byte compared in a slot whose length matches (one name memory port), a
// commit unless the table is full, a copy per byte of a newly stored name, an emit.
// done_o pulses the cycle after emit; the receiver cannot stall it.
// Reset clears the table at once through per-slot valid bits; no clearing pass.
`default_nettype none
module hash_table_name_counter (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  hntc_pkg::item_t    item_i,
  input  wire logic          cfg_we_i,
  input  wire logic          cfg_wdata_i,
  output hntc_pkg::result_t  res_o,
  output logic               done_o
);

  hntc_pkg::cmd_t  cmd;
  hntc_pkg::stat_t stat;

  hntc_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .busy_o (busy),
    .stat_i (stat),
    .cmd_o  (cmd)
  );

  hntc_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res_o),
    .done_o     (done_o)
  );

endmodule
`default_nettype wire

[dv/tb_top.sv]
// Testbench for the hash table name counter: scoreboard with a table predictor, random names.
`timescale 1ns / 100ps
module tb_top;

  localparam int CycleLimit = 40000000;

  class name_count_sb;
    logic [hntc_pkg::CharW-1:0]  slot_name [hntc_pkg::TableSize][hntc_pkg::NameBytes];
    int                          slot_len  [hntc_pkg::TableSize];
    logic [hntc_pkg::CountW-1:0] slot_cnt  [hntc_pkg::TableSize];
    logic [hntc_pkg::CharW-1:0]  key_buf   [hntc_pkg::NameBytes];
    int                          key_len;
    int                          run_hash;
    int                          distinct;
    int                          coll;
    bit                          hash_sel;
    hntc_pkg::result_t           pending_results[$];
    int                          mismatches;

    function new();
      for (int i = 0; i < hntc_pkg::TableSize; i++) begin
        slot_len[i] = 0;
        slot_cnt[i] = '0;
      end
      key_len = 0; run_hash = 0; distinct = 0; coll = 0; hash_sel = 1'b1; mismatches = 0;
    endfunction

    function int weight(int c);
      if (!hash_sel) return c;
      if (c == "o" || c == "O") return c * 31;
      if (c == "n" || c == "N") return c * 51;
      if (c == "v" || c == "V") return c / 7;
      if (c == "e" || c == "E") return c * 71;
      return c;
    endfunction

    function int next_slot(int x);
      int v;
      v = x * 8241;
      if (v < 20000) v = (v >= 279) ? v - 279 : 279 - v;
      else v = v + 371;
      return v % hntc_pkg::TableSize;
    endfunction

    function bit name_at(int s);
      if (slot_len[s] != key_len) return 1'b0;
      for (int i = 0; i < key_len; i++)
        if (slot_name[s][i] != key_buf[i]) return 1'b0;
      return 1'b1;
    endfunction

    // accepted input beat: update the key, predict on the last character
    function void note_item(hntc_pkg::item_t it);
      int                s;
      bit                hit;
      bit                full;
      hntc_pkg::result_t r;
      hit = 1'b0; full = 1'b0;
      if (it.char_code != 0 && key_len < hntc_pkg::NameBytes) begin
        key_buf[key_len] = it.char_code;
        key_len++;
        run_hash = (run_hash + weight(int'(it.char_code))) % hntc_pkg::TableSize;
      end
      if (!it.last) return;
      s = run_hash;
      for (int k = 0; k < hntc_pkg::TableSize; k++) begin
        if (slot_cnt[s] == 0) break;
        if (name_at(s)) begin
          hit = 1'b1;
          break;
        end
        if (k + 1 == hntc_pkg::TableSize) begin
          full = 1'b1;
          break;
        end
        s = next_slot(s);
        if (it.action == hntc_pkg::ACT_INSERT && coll < 65535) coll++;
      end
      r = '0;
      if (!full) begin
        if (it.action == hntc_pkg::ACT_INSERT) begin
          if (!hit) begin
            for (int i = 0; i < key_len; i++) slot_name[s][i] = key_buf[i];
            slot_len[s] = key_len;
            distinct++;
          end
          if (slot_cnt[s] != hntc_pkg::CountMax) slot_cnt[s]++;
        end
        r.occurrences = slot_cnt[s];
      end
      r.found          = hit;
      r.slot           = 7'(s);
      r.table_full     = full;
      r.distinct_names = 7'(distinct);
      r.collisions     = 16'(coll);
      pending_results.push_back(r);
      key_len = 0;
      run_hash = 0;
    endfunction

    function void check_result(hntc_pkg::result_t got);
      hntc_pkg::result_t exp_r;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result beat %p", got);
        return;
      end
      exp_r = pending_results.pop_front();
      if (got.found !== exp_r.found || got.occurrences !== exp_r.occurrences ||
          got.slot !== exp_r.slot || got.table_full !== exp_r.table_full ||
          got.distinct_names !== exp_r.distinct_names ||
          got.collisions !== exp_r.collisions) begin
        mismatches++;
        if (mismatches <= 10) $display("mismatch: expected %p, got %p", exp_r, got);
      end
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  hntc_pkg::item_t   item_i = '0;
  logic              cfg_we_i = 1'b0;
  logic              cfg_wdata_i = 1'b0;
  hntc_pkg::result_t res_o;
  logic              done_o;

  name_count_sb sb = new();
  int           items_sent = 0;
  int           idle_pct = 0;
  int           cycles = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  hash_table_name_counter u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .item_i     (item_i),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .res_o      (res_o),
    .done_o     (done_o)
  );

  always @(negedge clk_i) begin
    if (rst_ni && done_o === 1'b1) sb.check_result(res_o);
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_item(logic act, logic [hntc_pkg::CharW-1:0] c, logic lst);
    hntc_pkg::item_t it;
    logic            b;
    it.action = act; it.char_code = c; it.last = lst;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < idle_pct) @(posedge clk_i);
    end
    start  <= 1'b1;
    item_i <= it;
    do begin
      @(negedge clk_i);
      b = busy;
      @(posedge clk_i);
    end while (b);
    sb.note_item(it);
    items_sent++;
  endtask

  task automatic send_name(logic act, logic [hntc_pkg::CharW-1:0] nm[$]);
    if (nm.size() == 0) send_item(act, 7'd0, 1'b1);
    for (int i = 0; i < nm.size(); i++)
      send_item(i == nm.size() - 1 ? act : logic'($urandom_range(1)), nm[i],
                i == nm.size() - 1);
  endtask

  // sender pause: all predicted results in, block idle
  task automatic drain();
    start <= 1'b0;
    @(posedge clk_i);
    while (sb.pending_results.size() != 0 || busy) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
  endtask

  task automatic write_select(logic v);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    sb.hash_sel = v;
  endtask

  function automatic logic [hntc_pkg::CharW-1:0] rand_char();
    int p;
    p = $urandom_range(99);
    if (p < 30) begin
      case ($urandom_range(7))
        0: return "o"; 1: return "O"; 2: return "n"; 3: return "N";
        4: return "v"; 5: return "V"; 6: return "e"; default: return "E";
      endcase
    end
    if (p < 90) return 7'($urandom_range(126, 32));
    return 7'($urandom_range(127));
  endfunction

  logic [hntc_pkg::CharW-1:0] name_pool[48][$];
  logic [hntc_pkg::CharW-1:0] nm[$];
  int                         len;
  int                         p;

  initial begin
    for (int i = 0; i < 48; i++) begin
      p = $urandom_range(99);
      len = p < 8 ? 0 : (p < 90 ? $urandom_range(8, 1) : $urandom_range(40, 25));
      for (int j = 0; j < len; j++) name_pool[i].push_back(rand_char());
    end
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: weighted letters, repeats, lookups, empty name, zero characters
    write_select(1'b1);
    nm = '{"o", "n"};       send_name(hntc_pkg::ACT_INSERT, nm);
    send_name(hntc_pkg::ACT_INSERT, nm);
    send_name(hntc_pkg::ACT_LOOKUP, nm);
    nm = '{"v", "e"};       send_name(hntc_pkg::ACT_LOOKUP, nm);
    nm = '{"E", "v", "N"};  send_name(hntc_pkg::ACT_INSERT, nm);
    nm = {};                send_name(hntc_pkg::ACT_INSERT, nm);
    nm = '{"x", 7'd0};      send_name(hntc_pkg::ACT_INSERT, nm);
    nm = '{"a", 7'd0, "b"}; send_name(hntc_pkg::ACT_INSERT, nm);
    nm = '{7'd127, "V", "O"}; send_name(hntc_pkg::ACT_LOOKUP, nm);
    nm = '{7'd127, "V", "O"}; send_name(hntc_pkg::ACT_INSERT, nm);

    // random names, mostly from a shared pool so that repeats are common
    for (int ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 71;
        2: idle_pct = 25;
        default: idle_pct = 0;
      endcase
      write_select(ph[0] ? 1'b0 : 1'b1);
      while (items_sent < 220 * (ph + 1)) begin
        if (ph == 1 && items_sent > 370 && items_sent < 380) drain();
        if ($urandom_range(9) == 0) begin
          nm = {};
          len = $urandom_range(6);
          for (int j = 0; j < len; j++) nm.push_back(7'($urandom_range(127)));
        end else nm = name_pool[$urandom_range(47)];
        send_name(logic'($urandom_range(3) == 0), nm);
      end
    end

    // fill the table with distinct names until probing runs out of slots
    idle_pct = 10;
    write_select(1'b1);
    for (int i = 0; i < 115; i++) begin
      nm = '{"#", 7'(65 + i % 26), 7'(97 + i / 26)};
      send_name(hntc_pkg::ACT_INSERT, nm);
    end
    for (int i = 0; i < 20; i++) begin
      nm = name_pool[$urandom_range(47)];
      send_name(logic'($urandom_range(1)), nm);
    end
    write_select(1'b0);
    for (int i = 0; i < 10; i++) begin
      nm = '{"#", 7'($urandom_range(90, 65)), 7'($urandom_range(122, 97))};
      send_name(logic'($urandom_range(1)), nm);
    end

    drain();
    repeat (20) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/hntc_pkg.sv
rtl/hntc_ctrl.sv
rtl/hntc_dp.sv
rtl/hash_table_name_counter.sv
dv/tb_top.sv
